>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define ZBD_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// default clk_i / rst_ni
`define ZBD_ASSERT(label, prop, msg) \
  `ZBD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/zbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbd_pkg
// Types and opcode constants for the Z80 branch decoder.
// ----------------------------------------------------------------------------
package zbd_pkg;

  typedef enum logic [2:0] {
    KIND_JP   = 3'd0,
    KIND_JR   = 3'd1,
    KIND_CALL = 3'd2,
    KIND_RET  = 3'd3,
    KIND_RETI = 3'd4,
    KIND_RST  = 3'd5,
    KIND_DJNZ = 3'd6
  } zbd_kind_e;

  typedef struct packed {
    logic [7:0]  opcode_byte;
    logic [7:0]  operand_byte;
    logic [7:0]  third_byte;
    logic [15:0] program_counter;
    logic [7:0]  flag_bits;
    logic [7:0]  b_register;
    logic [15:0] hl_pair;
    logic [15:0] ix_pair;
    logic [15:0] iy_pair;
    logic [15:0] stack_word;
  } zbd_in_t;

  typedef struct packed {
    logic        is_control_flow;
    zbd_kind_e   kind;
    logic [15:0] target_address;
    logic        branch_taken;
    logic [1:0]  length;
  } zbd_out_t;

  // flag bit positions in F
  localparam int unsigned FLAG_C  = 0;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_S  = 7;

  // condition codes
  localparam logic [2:0] CC_NZ = 3'd0;
  localparam logic [2:0] CC_Z  = 3'd1;
  localparam logic [2:0] CC_NC = 3'd2;
  localparam logic [2:0] CC_C  = 3'd3;
  localparam logic [2:0] CC_PO = 3'd4;
  localparam logic [2:0] CC_PE = 3'd5;
  localparam logic [2:0] CC_P  = 3'd6;
  localparam logic [2:0] CC_M  = 3'd7;

  // opcodes
  localparam logic [7:0] OP_PFX_IX  = 8'hDD;
  localparam logic [7:0] OP_PFX_IY  = 8'hFD;
  localparam logic [7:0] OP_PFX_ED  = 8'hED;
  localparam logic [7:0] OP_JP_IND  = 8'hE9;
  localparam logic [7:0] OP_DJNZ    = 8'h10;
  localparam logic [7:0] OP_JR      = 8'h18;
  localparam logic [7:0] OP_JR_NZ   = 8'h20;
  localparam logic [7:0] OP_JR_Z    = 8'h28;
  localparam logic [7:0] OP_JR_NC   = 8'h30;
  localparam logic [7:0] OP_JR_C    = 8'h38;
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] ED_RETI    = 8'h4D;
  localparam logic [7:0] ED_RETN    = 8'h45;

  // opcode groups: (op & MASK_CC) == GRP_*
  localparam logic [7:0] MASK_CC    = 8'hC7;
  localparam logic [7:0] GRP_JP_CC  = 8'hC2;
  localparam logic [7:0] GRP_CALL_CC = 8'hC4;
  localparam logic [7:0] GRP_RET_CC = 8'hC0;
  localparam logic [7:0] GRP_RST    = 8'hC7;
  localparam logic [7:0] MASK_RST   = 8'h38;

  localparam logic [1:0] LEN_1 = 2'd1;
  localparam logic [1:0] LEN_2 = 2'd2;
  localparam logic [1:0] LEN_3 = 2'd3;

endpackage

>>> rtl/zbd_cond.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbd_cond
// Evaluates a Z80 condition code against the F register.
// ----------------------------------------------------------------------------
module zbd_cond (
  input  logic [2:0] cc_i,
  input  logic [7:0] flags_i,
  output logic       holds_o
);
  import zbd_pkg::*;

  always_comb begin
    unique case (cc_i)
      CC_NZ:   holds_o = !flags_i[FLAG_Z];
      CC_Z:    holds_o =  flags_i[FLAG_Z];
      CC_NC:   holds_o = !flags_i[FLAG_C];
      CC_C:    holds_o =  flags_i[FLAG_C];
      CC_PO:   holds_o = !flags_i[FLAG_PV];
      CC_PE:   holds_o =  flags_i[FLAG_PV];
      CC_P:    holds_o = !flags_i[FLAG_S];
      CC_M:    holds_o =  flags_i[FLAG_S];
      default: holds_o = 1'b0;
    endcase
  end

endmodule

>>> rtl/zbd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbd_decode
// Single-pass classification of one instruction request.
// ----------------------------------------------------------------------------
module zbd_decode (
  input  zbd_pkg::zbd_in_t  req_i,
  output zbd_pkg::zbd_out_t res_o
);
  import zbd_pkg::*;

  logic [7:0]  op;
  logic [7:0]  b1;
  logic [15:0] abs_addr;
  logic [15:0] rel_addr;
  logic        cc_full_holds;
  logic        cc_jr_holds;

  assign op       = req_i.opcode_byte;
  assign b1       = req_i.operand_byte;
  assign abs_addr = {req_i.third_byte, b1};
  assign rel_addr = req_i.program_counter + 16'd2 + {{8{b1[7]}}, b1};

  zbd_cond u_cond_full (
    .cc_i    (op[5:3]),
    .flags_i (req_i.flag_bits),
    .holds_o (cc_full_holds)
  );

  // JR cc only uses NZ, Z, NC, C
  zbd_cond u_cond_jr (
    .cc_i    ({1'b0, op[4:3]}),
    .flags_i (req_i.flag_bits),
    .holds_o (cc_jr_holds)
  );

  always_comb begin
    res_o = '0;
    priority if (op == OP_PFX_IX || op == OP_PFX_IY) begin
      if (b1 == OP_JP_IND) begin
        res_o.is_control_flow = 1'b1;
        res_o.kind            = KIND_JP;
        res_o.target_address  = (op == OP_PFX_IX) ? req_i.ix_pair : req_i.iy_pair;
        res_o.branch_taken    = 1'b1;
        res_o.length          = LEN_2;
      end
    end else if (op == OP_PFX_ED) begin
      if (b1[7:6] == ED_RETI[7:6] && b1[3:0] == ED_RETI[3:0]) begin
        res_o.is_control_flow = 1'b1;
        res_o.kind            = KIND_RETI;
        res_o.target_address  = req_i.stack_word;
        res_o.branch_taken    = 1'b1;
        res_o.length          = LEN_2;
      end else if (b1[7:6] == ED_RETN[7:6] && b1[3:0] == ED_RETN[3:0]) begin
        res_o.is_control_flow = 1'b1;
        res_o.kind            = KIND_RET;
        res_o.target_address  = req_i.stack_word;
        res_o.branch_taken    = 1'b1;
        res_o.length          = LEN_2;
      end
    end else if (op == OP_DJNZ) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_DJNZ;
      res_o.target_address  = rel_addr;
      res_o.branch_taken    = (req_i.b_register != 8'd1);
      res_o.length          = LEN_2;
    end else if (op == OP_JR) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_JR;
      res_o.target_address  = rel_addr;
      res_o.branch_taken    = 1'b1;
      res_o.length          = LEN_2;
    end else if (op == OP_JR_NZ || op == OP_JR_Z || op == OP_JR_NC || op == OP_JR_C) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_JR;
      res_o.target_address  = rel_addr;
      res_o.branch_taken    = cc_jr_holds;
      res_o.length          = LEN_2;
    end else if (op == OP_JP) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_JP;
      res_o.target_address  = abs_addr;
      res_o.branch_taken    = 1'b1;
      res_o.length          = LEN_3;
    end else if (op == OP_CALL) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_CALL;
      res_o.target_address  = abs_addr;
      res_o.branch_taken    = 1'b1;
      res_o.length          = LEN_3;
    end else if (op == OP_RET) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_RET;
      res_o.target_address  = req_i.stack_word;
      res_o.branch_taken    = 1'b1;
      res_o.length          = LEN_1;
    end else if (op == OP_JP_IND) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_JP;
      res_o.target_address  = req_i.hl_pair;
      res_o.branch_taken    = 1'b1;
      res_o.length          = LEN_1;
    end else if ((op & MASK_CC) == GRP_JP_CC) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_JP;
      res_o.target_address  = abs_addr;
      res_o.branch_taken    = cc_full_holds;
      res_o.length          = LEN_3;
    end else if ((op & MASK_CC) == GRP_CALL_CC) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_CALL;
      res_o.target_address  = abs_addr;
      res_o.branch_taken    = cc_full_holds;
      res_o.length          = LEN_3;
    end else if ((op & MASK_CC) == GRP_RET_CC) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_RET;
      res_o.target_address  = req_i.stack_word;
      res_o.branch_taken    = cc_full_holds;
      res_o.length          = LEN_1;
    end else if ((op & MASK_CC) == GRP_RST) begin
      res_o.is_control_flow = 1'b1;
      res_o.kind            = KIND_RST;
      res_o.target_address  = {8'h00, op & MASK_RST};
      res_o.branch_taken    = 1'b1;
      res_o.length          = LEN_1;
    end else begin
      // not control flow
      res_o = '0;
    end
  end

endmodule

>>> rtl/z80_branch_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80_branch_decoder
// Control-flow classifier for Z80 instructions, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one request:
//   the first three instruction bytes plus PC, F, B, HL, IX, IY and the
//   word at SP. Output channel out_valid_o / out_stall_i / out_req_o
//   returns one result per request: control-flow flag, kind, target,
//   taken flag and length (all zero when not control flow).
//   An accepted request sits in the input register, is decoded, and
//   enters the result register when out_stall_i does not hold it;
//   out_valid_o then rises. Throughput: one request per cycle unless
//   stalled, set by the single decode pass between the two registers.
//   Stall: while the result register is held by out_stall_i, the input
//   register still takes one more request; in_stall_o rises only when
//   both registers are full and the output is stalled.
//   Reset: both valid flags clear; no request is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module z80_branch_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  zbd_pkg::zbd_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output zbd_pkg::zbd_out_t out_req_o
);
  import zbd_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  zbd_in_t  s1_req_q;
  logic     out_valid_q, out_valid_d;
  zbd_out_t out_q;
  zbd_out_t dec_res;
  logic     s1_ready;
  logic     s2_ready;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  zbd_decode u_decode (
    .req_i (s1_req_q),
    .res_o (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_req_q <= in_req_i;
    end
    if (s2_ready && s1_valid_q) begin
      out_q <= dec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `ZBD_ASSERT(a_accept_fills_s1, (in_valid_i && !in_stall_o) |=> s1_valid_q, "request lost")
  `ZBD_ASSERT(a_s1_moves_out, (s1_valid_q && s2_ready) |=> out_valid_q, "decode lost")
  `ZBD_ASSERT(a_stall_only_full, in_stall_o |-> (s1_valid_q && out_valid_q), "stall not full")
  `ZBD_ASSERT(a_non_cf_zero, (out_valid_q && !out_q.is_control_flow) |-> (out_q == '0), "nz")
  `ZBD_ASSERT(a_cf_len, (out_valid_q && out_q.is_control_flow) |-> (out_q.length != 2'd0), "len")

endmodule
